@@ design/fhs_pkg.sv @@
// ---------------------------------------------------------------------------
// fhs_pkg
// Shared types and constants for the family histogram statistics block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fhs_pkg;

  localparam int DEPTH      = 1024;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = 17;           // bin count and item total width
  localparam int DW         = 11;           // domain register width
  localparam int SW         = 33;           // square sum width
  localparam int TSW        = 34;           // total squared width
  localparam int NUMW       = TSW + 16;     // widest dividend
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [CW-1:0] MAX_ITEMS    = CW'(65536);
  localparam logic [DW-1:0] DOMAIN_RESET = DW'(1024);
  localparam logic [DW-1:0] DEPTH_DOM    = DW'(DEPTH);

  typedef struct packed {
    logic signed [11:0] family_id;
    logic               last_item;
  } in_t;

  typedef struct packed {
    logic [10:0] families_found;
    logic [16:0] largest_family;
    logic [16:0] items_seen;
    logic [32:0] sq_sum;
    logic [16:0] largest_fraction;
    logic [16:0] mean_square_share;
    logic [26:0] effective_families;
  } out_t;

  // one queued item after classification
  typedef struct packed {
    logic          bin_en;
    logic [AW-1:0] addr;
    logic          last;
  } qent_t;

  // back part status seen by the front part
  typedef struct packed {
    logic clearing;
    logic set_done;
  } back_stat_t;

endpackage
`default_nettype wire

@@ design/fhs_div.sv @@
// ---------------------------------------------------------------------------
// fhs_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fhs_div
  import fhs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NUMW-1:0] num,
  input  wire logic [TSW-1:0]  den,
  output logic                 done,
  output logic [NUMW-1:0]      quo
);

  localparam int CNTW = $clog2(NUMW);

  logic [NUMW-1:0] num_r, num_nxt;
  logic [TSW-1:0]  rem_r, rem_nxt;
  logic [TSW-1:0]  den_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [TSW:0]    trial;
  logic            qbit;

  // shift in one dividend bit and try the subtraction
  always_comb begin
    trial    = {rem_r, num_r[NUMW-1]};
    qbit     = (trial >= {1'b0, den_r});
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      num_nxt  = num;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? TSW'(trial - {1'b0, den_r}) : trial[TSW-1:0];
      num_nxt = {num_r[NUMW-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(NUMW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule
`default_nettype wire

@@ design/fhs_queue.sv @@
// ---------------------------------------------------------------------------
// fhs_queue
// Short queue of classified items between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fhs_queue
  import fhs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire qent_t push_ent,
  input  wire logic  pop,
  output qent_t      head,
  output logic       empty,
  output logic       full
);

  qent_t          q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_ent;
    end
  end

  assign head  = q_r[rp_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QAW+1)'(QDEPTH));

endmodule
`default_nettype wire

@@ design/fhs_front.sv @@
// ---------------------------------------------------------------------------
// fhs_front
// Accepts identifiers, counts the set, classifies items for binning.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fhs_front
  import fhs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire in_t        in_data,
  output logic            busy,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [10:0] cfg_data,
  input  wire back_stat_t bstat,
  input  wire logic       q_full,
  output logic            push,
  output qent_t           push_ent,
  output logic [CW-1:0]   total
);

  logic [DW-1:0] domain_r;
  logic [DW-1:0] dom_eff;
  logic [CW-1:0] total_r;
  logic          pend_r;
  logic          accept;
  logic          room;
  logic          in_range;

  assign cfg_ready = 1'b1;
  assign busy      = pend_r | q_full | bstat.clearing;
  assign accept    = start & ~busy;
  assign room      = (total_r < MAX_ITEMS);

  // clamp the domain to the histogram depth and test the identifier
  always_comb begin
    dom_eff  = (domain_r > DEPTH_DOM) ? DEPTH_DOM : domain_r;
    in_range = ~in_data.family_id[11] & (in_data.family_id[10:0] < dom_eff);
    push     = accept & (room | in_data.last_item);
    push_ent.bin_en = room & in_range;
    push_ent.addr   = in_data.family_id[AW-1:0];
    push_ent.last   = in_data.last_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      domain_r <= DOMAIN_RESET;
      total_r  <= '0;
      pend_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        domain_r <= cfg_data;
      end
      // drop the set on completion, count each transfer below the item limit otherwise
      if (bstat.set_done) begin
        total_r <= '0;
        pend_r  <= 1'b0;
      end else if (accept) begin
        if (room) begin
          total_r <= total_r + 1'b1;
        end
        if (in_data.last_item) begin
          pend_r <= 1'b1;
        end
      end
    end
  end

  assign total = total_r;

endmodule
`default_nettype wire

@@ design/fhs_back.sv @@
// ---------------------------------------------------------------------------
// fhs_back
// Histogram memory updates, end-of-set scan and ratio division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fhs_back
  import fhs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire qent_t    head,
  input  wire logic     q_empty,
  output logic          pop,
  input  wire logic [CW-1:0] total,
  output back_stat_t    bstat,
  output logic          out_strobe,
  output out_t          out_data
);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WR     = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_DSTART = 3'd5;
  localparam logic [2:0] ST_DWAIT  = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   ent_addr_r;
  logic            last_r;
  logic [1:0]      sel_r;
  logic            p1_r, p2_r;
  logic [CW-1:0]   mem [DEPTH];
  logic [CW-1:0]   rdata_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [CW-1:0]   mem_wdata;
  logic [2*CW-1:0] sq_r;
  logic [TSW-1:0]  tot_sq;
  logic [TSW-1:0]  tsq_r;
  logic [10:0]     nonempty_r;
  logic [CW-1:0]   largest_r;
  logic [SW-1:0]   sumsq_r;
  logic [16:0]     frac_r, share_r;
  logic [26:0]     eff_r;
  logic            div_start, div_done;
  logic [NUMW-1:0] div_num, div_quo;
  logic [TSW-1:0]  div_den;

  // sequence the memory ports and the set phases
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_r;
    mem_raddr = addr_r;
    mem_wdata = '0;
    pop       = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_CLR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.bin_en) begin
            mem_re    = 1'b1;
            mem_raddr = head.addr;
            state_nxt = ST_WR;
          end else if (head.last) begin
            addr_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ent_addr_r;
        mem_wdata = rdata_r + 1'b1;
        if (last_r) begin
          addr_nxt  = '0;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        mem_re   = 1'b1;
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_r && !p2_r) begin
          state_nxt = ST_DSTART;
        end
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          state_nxt = (sel_r == 2'd2) ? ST_OUT : ST_DSTART;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // pick the operands of the current ratio
  always_comb begin
    case (sel_r)
      2'd0: begin
        div_num = NUMW'({largest_r, 16'b0});
        div_den = TSW'(total);
      end
      2'd1: begin
        div_num = NUMW'({sumsq_r, 16'b0});
        div_den = tsq_r;
      end
      default: begin
        div_num = {tsq_r, 16'b0};
        div_den = TSW'(sumsq_r);
      end
    endcase
  end

  fhs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // histogram memory
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      addr_r  <= '0;
      p1_r    <= 1'b0;
      p2_r    <= 1'b0;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      p1_r    <= (state_r == ST_SCAN);
      p2_r    <= p1_r;
      if (state_r == ST_OUT) begin
        sel_r <= '0;
      end else if (state_r == ST_DWAIT && div_done) begin
        sel_r <= sel_r + 1'b1;
      end
    end
  end

  // accumulate the scan, clear it on the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0;
      largest_r  <= '0;
      sumsq_r    <= '0;
    end else if (state_r == ST_OUT) begin
      nonempty_r <= '0;
      largest_r  <= '0;
      sumsq_r    <= '0;
    end else begin
      if (p1_r && rdata_r != '0) begin
        nonempty_r <= nonempty_r + 1'b1;
        if (rdata_r > largest_r) begin
          largest_r <= rdata_r;
        end
      end
      if (p2_r) begin
        sumsq_r <= sumsq_r + SW'(sq_r);
      end
    end
  end

  // square the item total at full product width
  assign tot_sq = total * total;

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_addr_r <= head.addr;
      last_r     <= head.last;
    end
    sq_r  <= rdata_r * rdata_r;
    tsq_r <= tot_sq;
    if (state_r == ST_DWAIT && div_done) begin
      case (sel_r)
        2'd0:    frac_r  <= div_quo[16:0];
        2'd1:    share_r <= div_quo[16:0];
        default: eff_r   <= (sumsq_r == '0) ? '0 : div_quo[26:0];
      endcase
    end
  end

  assign bstat.clearing = (state_r == ST_CLR);
  assign bstat.set_done = (state_r == ST_OUT);
  assign out_strobe     = (state_r == ST_OUT);

  assign out_data.families_found     = nonempty_r;
  assign out_data.largest_family     = largest_r;
  assign out_data.items_seen         = total;
  assign out_data.sq_sum             = sumsq_r;
  assign out_data.largest_fraction   = frac_r;
  assign out_data.mean_square_share  = share_r;
  assign out_data.effective_families = eff_r;

`ifndef SYNTHESIS
  a_out_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |=> state_r == ST_IDLE)
    else $error("result strobe held beyond one cycle");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == ST_IDLE && !q_empty)
    else $error("queue popped outside idle");
  a_scan_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && mem_we) |-> mem_wdata == '0)
    else $error("scan writes a non-zero bin");
  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> state_r == ST_DWAIT)
    else $error("divider restarted while waiting");
`endif

endmodule
`default_nettype wire

@@ design/family_histogram_statistics_top.sv @@
// ---------------------------------------------------------------------------
// family_histogram_statistics_top
// Histogram of family identifiers with diversity statistics per set.
// ---------------------------------------------------------------------------
// Each binned identifier takes a read-modify-write of the histogram memory, others are
// only popped; a 4-entry queue lets start be taken while the memory works.
// After the last item: a scan of all 1024 bins that also clears them, a drain of the
// scan pipeline, then 3 divisions (start, 50 quotient bits, done) on one shared divider.
// The result strobe lasts one cycle and the receiver cannot stall it.
// After reset the memory is cleared, all 1024 bins, while busy is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module family_histogram_statistics_top
  import fhs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire in_t         in_data,
  output logic             busy,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data,
  output logic             out_strobe,
  output out_t             out_data
);

  back_stat_t    bstat;
  logic          q_full, q_empty;
  logic          push, pop;
  qent_t         push_ent, head;
  logic [CW-1:0] total;

  fhs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .bstat     (bstat),
    .q_full    (q_full),
    .push      (push),
    .push_ent  (push_ent),
    .total     (total)
  );

  fhs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  fhs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .total      (total),
    .bstat      (bstat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

@@ dv/tb_family_histogram_statistics_top.sv @@
// ---------------------------------------------------------------------------
// tb_family_histogram_statistics_top
// Self-checking bench for the family histogram statistics block: directed
// table of identifier sets, then random sets under several domain settings,
// each result checked field by field against a behavioural histogram model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_family_histogram_statistics_top;
  import fhs_pkg::*;

  localparam int LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  in_t         in_data;
  logic        busy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;
  logic        out_strobe;
  out_t        out_data;

  // histogram model state
  int unsigned    model_bins [DEPTH];
  int unsigned    model_items;
  logic [10:0]    model_domain;
  out_t           stats_expected [$];
  int             err_count;
  int             results_seen;
  int             sets_sent;
  int             cycle_count;
  int             send_gap_pct;

  // directed sets: id, last, typed-in expected (only checked where known)
  typedef struct {
    logic signed [11:0] id;
    logic               last;
    logic               known;
    out_t               want;
  } row_t;
  row_t dir_rows [$];

  family_histogram_statistics_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d (set %0d)", what, got, want, results_seen);
    err_count++;
  endtask

  // fold one accepted item into the histogram; returns stats on a last item
  function automatic bit histogram_update(input in_t it, output out_t st);
    int unsigned dom;
    logic [63:0] tot, tsq, sq, big, nz;
    dom = (model_domain > DEPTH) ? DEPTH : model_domain;
    if (model_items < 65536) begin
      model_items++;
      if (!it.family_id[11] && int'(it.family_id) < dom)
        model_bins[it.family_id]++;
    end
    if (!it.last_item) return 1'b0;
    sq = 0; big = 0; nz = 0;
    foreach (model_bins[i]) begin
      if (model_bins[i] != 0) begin
        nz++;
        if (model_bins[i] > big) big = model_bins[i];
        sq += 64'(model_bins[i]) * 64'(model_bins[i]);
      end
      model_bins[i] = 0;
    end
    tot = model_items;
    tsq = tot * tot;
    st.families_found     = 11'(nz);
    st.largest_family     = 17'(big);
    st.items_seen         = 17'(tot);
    st.sq_sum             = 33'(sq);
    st.largest_fraction   = 17'((big << 16) / tot);
    st.mean_square_share  = 17'((sq << 16) / tsq);
    st.effective_families = (sq != 0) ? 27'((tsq << 16) / sq) : 27'd0;
    model_items = 0;
    return 1'b1;
  endfunction

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    out_t w;
    if (rst_n && out_strobe) begin
      if (stats_expected.size() == 0) begin
        $display("unexpected result");
        err_count++;
      end else begin
        w = stats_expected.pop_front();
        if (out_data.families_found !== w.families_found)
          report_mismatch("families_found", out_data.families_found, w.families_found);
        if (out_data.largest_family !== w.largest_family)
          report_mismatch("largest_family", out_data.largest_family, w.largest_family);
        if (out_data.items_seen !== w.items_seen)
          report_mismatch("items_seen", out_data.items_seen, w.items_seen);
        if (out_data.sq_sum !== w.sq_sum)
          report_mismatch("sq_sum", out_data.sq_sum, w.sq_sum);
        if (out_data.largest_fraction !== w.largest_fraction)
          report_mismatch("largest_fraction", out_data.largest_fraction,
                          w.largest_fraction);
        if (out_data.mean_square_share !== w.mean_square_share)
          report_mismatch("mean_square_share", out_data.mean_square_share,
                          w.mean_square_share);
        if (out_data.effective_families !== w.effective_families)
          report_mismatch("effective_families", out_data.effective_families,
                          w.effective_families);
      end
      results_seen++;
    end
  end

  // present one item and hold it until the transfer; random idle cycles first,
  // start stays high for a following item
  task automatic send_item(input logic signed [11:0] id, input logic last,
                           input bit known, input out_t want);
    in_t  it;
    out_t st;
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    it.family_id = id;
    it.last_item = last;
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (histogram_update(it, st)) begin
      if (known && st != want) begin
        $display("directed row disagrees with model");
        err_count++;
      end
      stats_expected.insert(stats_expected.size(), st);
      sets_sent++;
    end
    @(negedge clk);
  endtask

  // wait for every result, let the block settle, then write the domain
  task automatic write_domain(input logic [10:0] dom);
    start <= 1'b0;
    while (stats_expected.size() != 0) @(negedge clk);
    repeat (4200) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= dom;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_domain = dom;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random set: mostly small ids up to the given span, some noise
  task automatic random_set(input int len, input int unsigned span);
    logic signed [11:0] id;
    out_t none;
    none = '0;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(9))
        0:       id = 12'($urandom);
        1:       id = -12'sd1 - 12'($urandom_range(2047));
        default: id = 12'($urandom_range(span));
      endcase
      send_item(id, k == len - 1, 1'b0, none);
    end
  endtask

  function automatic row_t mk(input int id, input bit last, input bit known,
                              input out_t want);
    row_t r;
    r.id = 12'(id); r.last = last; r.known = known; r.want = want;
    return r;
  endfunction

  // append one row to the directed table
  task automatic add_row(input row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    out_t z, s1, s2;
    int   items;
    logic [10:0] doms [5];
    cycle_count = 0; err_count = 0; results_seen = 0; sets_sent = 0;
    model_items = 0; model_domain = DOMAIN_RESET; send_gap_pct = 0;
    foreach (model_bins[i]) model_bins[i] = 0;
    start = 1'b0; in_data = '0; cfg_valid = 1'b0; cfg_data = '0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // single binned item: one family of one
    s1 = '{families_found: 1, largest_family: 1, items_seen: 1, sq_sum: 1,
           largest_fraction: 17'h10000, mean_square_share: 17'h10000,
           effective_families: 27'h10000};
    // single ignored item: nothing binned
    z  = '{families_found: 0, largest_family: 0, items_seen: 1, sq_sum: 0,
           largest_fraction: 0, mean_square_share: 0, effective_families: 0};
    s2 = '0;
    add_row(mk(0, 1, 1, s1));
    add_row(mk(1023, 1, 1, s1));
    add_row(mk(1024, 1, 1, z));
    add_row(mk(2047, 1, 1, z));
    add_row(mk(-1, 1, 1, z));
    add_row(mk(-2048, 1, 1, z));
    add_row(mk(12'h555, 1, 1, z));
    add_row(mk(12'h2AA, 1, 1, s1));
    add_row(mk(5, 0, 0, s2));
    add_row(mk(5, 0, 0, s2));
    add_row(mk(7, 0, 0, s2));
    add_row(mk(-3, 1, 0, s2));
    foreach (dir_rows[i])
      send_item(dir_rows[i].id, dir_rows[i].last, dir_rows[i].known, dir_rows[i].want);

    // domain zero, then domain changed in the middle of a set
    write_domain(11'd0);
    dir_rows.delete();
    send_item(0, 1'b1, 1'b1, z);
    write_domain(11'd3);
    send_item(2, 1'b0, 1'b0, s2);
    send_item(3, 1'b0, 1'b0, s2);
    write_domain(11'd2047);
    send_item(900, 1'b0, 1'b0, s2);
    send_item(2, 1'b1, 1'b0, s2);

    // random sets over several domains and three idling phases
    doms = '{11'd1, 11'd1024, 11'd2047, 11'd17, 11'd200};
    items = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_domain(doms[ph]);
      send_gap_pct = (ph < 2) ? 8 : (ph < 4) ? 77 : 0;
      if (ph == 3) send_gap_pct = 0;
      while (items < (ph + 1) * 240) begin
        int len;
        len = ($urandom_range(7) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
        random_set(len, (doms[ph] > 40 && $urandom_range(1)) ? doms[ph] : 40);
        items += len;
      end
    end

    start <= 1'b0;
    while (stats_expected.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("%0d of %0d sets checked, %0d random items, domains 0..2047",
             results_seen, sets_sent, items);
    $display("directed extremes, domain changes mid-set and three idling phases");
    if (err_count == 0 && stats_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
